// File: sv/calclk_pkg.sv
// Shared types and constants for the calendar clock counter.
package calclk_pkg;

   // Item kinds on the request channel.
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   // ASCII code of the digit zero.
   localparam logic [7:0] ASCII_ZERO = 8'd48;

   // Rollover values, compared with the incremented count.
   localparam logic [6:0] SEC_ROLL   = 7'd60;
   localparam logic [6:0] MIN_ROLL   = 7'd60;
   localparam logic [5:0] HOUR_ROLL  = 6'd24;
   localparam logic [5:0] DAY_LIMIT  = 6'd32;
   localparam logic [4:0] MONTH_ROLL = 5'd13;

   // Month codes that have special day counts.
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;

   // Time after reset.
   localparam logic [4:0] RESET_HOUR   = 5'd0;
   localparam logic [5:0] RESET_MINUTE = 6'd0;
   localparam logic [5:0] RESET_SECOND = 6'd0;
   localparam logic [4:0] RESET_DAY    = 5'd1;
   localparam logic [3:0] RESET_MONTH  = 4'd1;
   localparam logic [7:0] RESET_YEAR   = 8'd15;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [4:0] day;
      logic [3:0] month;
      logic [7:0] year;
   } time_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] hour_text;
      logic [15:0] minute_text;
      logic [15:0] second_text;
      logic [15:0] day_text;
      logic [15:0] month_text;
      logic [15:0] year_text;
   } req_item_type;

   typedef struct packed {
      logic       time_valid;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [4:0] day;
      logic [3:0] month;
      logic [7:0] year;
   } rsp_item_type;

endpackage

// File: sv/calclk_convert.sv
// Conversion of six ASCII digit pairs into a binary time value.
module calclk_convert (
   input  calclk_pkg::req_item_type item,
   output calclk_pkg::time_type     load_time
);

   // Digits are not checked; the value wraps in eight bits.
   function automatic logic [7:0] pair_value(input logic [15:0] text);
      logic [7:0] tens;
      logic [7:0] ones;
      tens = text[15:8] - calclk_pkg::ASCII_ZERO;
      ones = text[7:0] - calclk_pkg::ASCII_ZERO;
      return 8'((tens << 3) + (tens << 1) + ones);
   endfunction

   logic [7:0] hour_val;
   logic [7:0] minute_val;
   logic [7:0] second_val;
   logic [7:0] day_val;
   logic [7:0] month_val;

   assign hour_val   = pair_value(item.hour_text);
   assign minute_val = pair_value(item.minute_text);
   assign second_val = pair_value(item.second_text);
   assign day_val    = pair_value(item.day_text);
   assign month_val  = pair_value(item.month_text);

   assign load_time.hour   = hour_val[4:0];
   assign load_time.minute = minute_val[5:0];
   assign load_time.second = second_val[5:0];
   assign load_time.day    = day_val[4:0];
   assign load_time.month  = month_val[3:0];
   assign load_time.year   = pair_value(item.year_text);

endmodule

// File: sv/calclk_advance.sv
// One-second advance of the calendar counters with full rollover cascade.
module calclk_advance (
   input  calclk_pkg::time_type cur_time,
   output calclk_pkg::time_type next_time
);

   logic [6:0] sec_sum;
   logic [6:0] min_sum;
   logic [5:0] hour_sum;
   logic [5:0] day_sum;
   logic       sec_wrap;
   logic       min_wrap;
   logic       hour_wrap;
   logic       leap;
   logic       month_end;
   logic [4:0] month_step;

   assign sec_sum  = {1'b0, cur_time.second} + 7'd1;
   assign min_sum  = {1'b0, cur_time.minute} + 7'd1;
   assign hour_sum = {1'b0, cur_time.hour} + 6'd1;
   assign day_sum  = {1'b0, cur_time.day} + 6'd1;

   assign sec_wrap  = (sec_sum == calclk_pkg::SEC_ROLL);
   assign min_wrap  = (min_sum == calclk_pkg::MIN_ROLL);
   assign hour_wrap = (hour_sum == calclk_pkg::HOUR_ROLL);
   assign leap      = (cur_time.year[1:0] == 2'd0);

   // The day rolls past 31 in any month, including codes that are not months.
   always_comb begin
      month_end = (day_sum == calclk_pkg::DAY_LIMIT);
      case (cur_time.month)
         calclk_pkg::MONTH_FEB: begin
            if (leap) begin
               month_end = month_end || (day_sum == 6'd30);
            end else begin
               month_end = month_end || (day_sum == 6'd29);
            end
         end
         calclk_pkg::MONTH_APR,
         calclk_pkg::MONTH_JUN,
         calclk_pkg::MONTH_SEP,
         calclk_pkg::MONTH_NOV: begin
            month_end = month_end || (day_sum == 6'd31);
         end
         default: begin
         end
      endcase
   end

   assign month_step = month_end ? ({1'b0, cur_time.month} + 5'd1)
                                 : {1'b0, cur_time.month};

   always_comb begin
      next_time = cur_time;
      if (sec_wrap) begin
         next_time.second = '0;
         if (min_wrap) begin
            next_time.minute = '0;
            if (hour_wrap) begin
               next_time.hour = '0;
               next_time.day  = month_end ? 5'd1 : day_sum[4:0];
               // Month thirteen folds into January of the next year, even
               // when it was already thirteen without a day rollover.
               if (month_step == calclk_pkg::MONTH_ROLL) begin
                  next_time.month = 4'd1;
                  next_time.year  = cur_time.year + 8'd1;
               end else begin
                  next_time.month = month_step[3:0];
               end
            end else begin
               next_time.hour = hour_sum[4:0];
            end
         end else begin
            next_time.minute = min_sum[5:0];
         end
      end else begin
         next_time.second = sec_sum[5:0];
      end
   end

endmodule

// File: sv/calendar_clock_counter.sv
// Top level of the calendar clock counter: handshake, clock state, result.
//
// Request items arrive on req_valid / req_stall / req_item. An item of kind
// tick advances the clock by one second once the clock is valid; an item of
// kind set loads the time from six ASCII digit pairs, but only while the
// clock is not yet valid, and then marks it valid. Every item, whatever its
// kind, returns one result item on rsp_valid / rsp_stall / rsp_item that
// carries the valid flag and the time after that item.
// An accepted item lands in an input register; once the result register can
// take it, the conversion and the rollover cascade work on it and the result
// and the new clock state are registered together. One item is taken every
// cycle as long as the receiver does not stall. The rate is set by the update
// of the clock registers, which every item reads and writes.
// When the receiver stalls, the result holds and the input register keeps
// its item; the input side is stalled only when both registers are full.
// Reset clears both stages and sets the clock to 00:00:00 on day 1, month 1,
// year 15, marked not valid.
module calendar_clock_counter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  calclk_pkg::req_item_type  req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output calclk_pkg::rsp_item_type  rsp_item
);

   localparam calclk_pkg::time_type RESET_TIME = '{
      hour:   calclk_pkg::RESET_HOUR,
      minute: calclk_pkg::RESET_MINUTE,
      second: calclk_pkg::RESET_SECOND,
      day:    calclk_pkg::RESET_DAY,
      month:  calclk_pkg::RESET_MONTH,
      year:   calclk_pkg::RESET_YEAR
   };

   logic                     in_valid_ff;
   calclk_pkg::req_item_type in_item_ff;
   logic                     out_valid_ff;
   calclk_pkg::rsp_item_type out_item_ff;
   logic                     out_valid_in;
   calclk_pkg::rsp_item_type out_item_in;
   logic                     clk_valid_ff;
   logic                     clk_valid_in;
   calclk_pkg::time_type     clk_time_ff;
   calclk_pkg::time_type     clk_time_in;
   calclk_pkg::time_type     load_time;
   calclk_pkg::time_type     tick_time;
   logic                     advance;
   logic                     req_take;

   // The result register can take a new item when it is empty or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   calclk_convert u_convert (
      .item      (in_item_ff),
      .load_time (load_time)
   );

   calclk_advance u_advance (
      .cur_time  (clk_time_ff),
      .next_time (tick_time)
   );

   // Next clock state for the item in the input register.
   always_comb begin
      clk_valid_in = clk_valid_ff;
      clk_time_in  = clk_time_ff;
      if (in_item_ff.kind == calclk_pkg::KIND_SET) begin
         if (!clk_valid_ff) begin
            clk_time_in  = load_time;
            clk_valid_in = 1'b1;
         end
      end else if (clk_valid_ff) begin
         clk_time_in = tick_time;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_item_in  = out_item_ff;
      if (advance && in_valid_ff) begin
         out_valid_in           = 1'b1;
         out_item_in.time_valid = clk_valid_in;
         out_item_in.hour       = clk_time_in.hour;
         out_item_in.minute     = clk_time_in.minute;
         out_item_in.second     = clk_time_in.second;
         out_item_in.day        = clk_time_in.day;
         out_item_in.month      = clk_time_in.month;
         out_item_in.year       = clk_time_in.year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         clk_valid_ff <= 1'b0;
         clk_time_ff  <= RESET_TIME;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && in_valid_ff) begin
            clk_valid_ff <= clk_valid_in;
            clk_time_ff  <= clk_time_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// File: tb/sv/tb_calendar_clock_counter.sv
// Self-checking testbench for the calendar clock counter: set, tick and rollover.
module tb_calendar_clock_counter;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles with no accepted item on either channel before the run is given up.
   localparam int unsigned QUIET_LIMIT = 2000;
   // Ticks per random phase; ignored sets come on top of these.
   localparam int unsigned PHASE_TICKS = 130;

   // Keeps its own copy of the clock, works out the time that each accepted
   // request leaves behind and checks the results in order against it.
   class calendar_tracker;
      bit                       is_set;
      logic [4:0]               hour;
      logic [5:0]               minute;
      logic [5:0]               second;
      logic [4:0]               day;
      logic [3:0]               month;
      logic [7:0]               year;
      calclk_pkg::rsp_item_type expected_times[$];
      int unsigned              failures;

      function new();
         is_set   = 1'b0;
         hour     = calclk_pkg::RESET_HOUR;
         minute   = calclk_pkg::RESET_MINUTE;
         second   = calclk_pkg::RESET_SECOND;
         day      = calclk_pkg::RESET_DAY;
         month    = calclk_pkg::RESET_MONTH;
         year     = calclk_pkg::RESET_YEAR;
         failures = 0;
      endfunction

      // Digits are not checked: a pair is tens*10 + ones in wrapping arithmetic.
      function logic [31:0] digits_value(logic [15:0] text);
         logic [31:0] tens;
         logic [31:0] ones;
         tens = text[15:8];
         ones = text[7:0];
         return 10 * (tens - calclk_pkg::ASCII_ZERO) + (ones - calclk_pkg::ASCII_ZERO);
      endfunction

      function bit month_closes(logic [31:0] next_day, logic [3:0] mon, logic [7:0] yr);
         if (next_day == calclk_pkg::DAY_LIMIT) return 1'b1;
         if (mon == calclk_pkg::MONTH_FEB)
            return (yr[1:0] == 2'd0) ? (next_day == 30) : (next_day == 29);
         if (mon == calclk_pkg::MONTH_APR || mon == calclk_pkg::MONTH_JUN ||
             mon == calclk_pkg::MONTH_SEP || mon == calclk_pkg::MONTH_NOV)
            return next_day == 31;
         return 1'b0;
      endfunction

      // Each stage compares the full sum with its rollover value; an
      // out-of-range count simply wraps at its width without a carry.
      function void advance_one_second();
         logic [31:0] sum;
         logic [4:0]  next_month;
         sum = second + 1;
         if (sum != calclk_pkg::SEC_ROLL) begin
            second = 6'(sum);
            return;
         end
         second = '0;
         sum = minute + 1;
         if (sum != calclk_pkg::MIN_ROLL) begin
            minute = 6'(sum);
            return;
         end
         minute = '0;
         sum = hour + 1;
         if (sum != calclk_pkg::HOUR_ROLL) begin
            hour = 5'(sum);
            return;
         end
         hour = '0;
         sum = day + 1;
         if (month_closes(sum, month, year)) begin
            day        = 5'd1;
            next_month = month + 5'd1;
         end else begin
            day        = 5'(sum);
            next_month = month;
         end
         // A next month of thirteen turns into January of the next year.
         if (next_month == calclk_pkg::MONTH_ROLL) begin
            next_month = 5'd1;
            year       = year + 8'd1;
         end
         month = next_month[3:0];
      endfunction

      function void note_request(calclk_pkg::req_item_type item);
         calclk_pkg::rsp_item_type want;
         if (item.kind == calclk_pkg::KIND_SET) begin
            if (!is_set) begin
               hour   = 5'(digits_value(item.hour_text));
               minute = 6'(digits_value(item.minute_text));
               second = 6'(digits_value(item.second_text));
               day    = 5'(digits_value(item.day_text));
               month  = 4'(digits_value(item.month_text));
               year   = 8'(digits_value(item.year_text));
               is_set = 1'b1;
            end
         end else if (is_set) begin
            advance_one_second();
         end
         want.time_valid = is_set;
         want.hour       = hour;
         want.minute     = minute;
         want.second     = second;
         want.day        = day;
         want.month      = month;
         want.year       = year;
         expected_times.push_back(want);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(calclk_pkg::rsp_item_type got);
         calclk_pkg::rsp_item_type want;
         if (expected_times.size() == 0) begin
            failures++;
            $display("%0t: result with nothing expected: expected none, got %h", $time, got);
            return;
         end
         want = expected_times.pop_front();
         check_field("time_valid", 8'(want.time_valid), 8'(got.time_valid));
         check_field("hour", 8'(want.hour), 8'(got.hour));
         check_field("minute", 8'(want.minute), 8'(got.minute));
         check_field("second", 8'(want.second), 8'(got.second));
         check_field("day", 8'(want.day), 8'(got.day));
         check_field("month", 8'(want.month), 8'(got.month));
         check_field("year", want.year, got.year);
      endfunction

      function int unsigned pending();
         return expected_times.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   calclk_pkg::req_item_type req_item = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   calclk_pkg::rsp_item_type rsp_item;

   int unsigned  send_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;
   int unsigned  quiet_cycles = 0;

   calendar_tracker tracker = new();

   calendar_clock_counter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver stalls at random, one decision per cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Both channels are sampled at the edge, so the values seen are the ones
   // that held just before it. A request is noted before a result is checked;
   // a result never comes in the same cycle as its own request.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_request(req_item);
         if (rsp_valid && !rsp_stall) tracker.check_result(rsp_item);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Offers one item, idling first at random, and holds it until accepted.
   task automatic send_request(input calclk_pkg::req_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [15:0] ascii_pair(int unsigned value);
      return {8'(calclk_pkg::ASCII_ZERO + value / 10), 8'(calclk_pkg::ASCII_ZERO + value % 10)};
   endfunction

   function automatic calclk_pkg::req_item_type clock_text(int unsigned h, int unsigned m,
                                                           int unsigned s, int unsigned d,
                                                           int unsigned mo, int unsigned y);
      return {calclk_pkg::KIND_SET, ascii_pair(h), ascii_pair(m), ascii_pair(s),
              ascii_pair(d), ascii_pair(mo), ascii_pair(y)};
   endfunction

   // Only the first set after reset is taken, and reset comes once, so each
   // run starts the clock from one point a few seconds before an interesting
   // midnight. The seed decides which one.
   function automatic calclk_pkg::req_item_type pick_start();
      int unsigned sec;
      int unsigned short_months[4] = '{calclk_pkg::MONTH_APR, calclk_pkg::MONTH_JUN,
                                       calclk_pkg::MONTH_SEP, calclk_pkg::MONTH_NOV};
      int unsigned long_months[6] = '{1, 3, 5, 7, 8, 10};
      int unsigned odd_months[3] = '{0, 14, 15};
      calclk_pkg::req_item_type item;
      sec = $urandom_range(59, 40);
      case ($urandom_range(9))
         // Last day of the year; year 255 wraps to 0.
         0: item = clock_text(23, 59, sec, 31, 12, 255);
         // Leap February ends on the 29th.
         1: item = clock_text(23, 59, sec, 29, calclk_pkg::MONTH_FEB, 4 * $urandom_range(24));
         // Leap February goes on past the 28th.
         2: item = clock_text(23, 59, sec, 28, calclk_pkg::MONTH_FEB, 4 * $urandom_range(24));
         // Common February ends on the 28th.
         3: item = clock_text(23, 59, sec, 28, calclk_pkg::MONTH_FEB,
                              4 * $urandom_range(24) + 1 + $urandom_range(2));
         4: item = clock_text(23, 59, sec, 30, short_months[$urandom_range(3)],
                              $urandom_range(99));
         5: item = clock_text(23, 59, sec, 31, long_months[$urandom_range(5)],
                              $urandom_range(99));
         // Month thirteen becomes January of the next year at midnight.
         6: item = clock_text(23, 59, sec, $urandom_range(30, 1), 13, $urandom_range(99));
         // Months out of range end only after day 31.
         7: item = clock_text(23, 59, sec, 31, odd_months[$urandom_range(2)],
                              $urandom_range(99));
         // Out-of-range second, minute and hour wrap without a carry.
         8: item = clock_text(31, 63, $urandom_range(63, 60), 15, 6, 40);
         // Arbitrary bytes instead of digits.
         default: item = {calclk_pkg::KIND_SET, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom)};
      endcase
      return item;
   endfunction

   // Mostly ticks; the sets are ignored once the clock is valid but still
   // return a result and carry arbitrary text.
   function automatic calclk_pkg::req_item_type random_request();
      calclk_pkg::req_item_type item;
      item.kind        = ($urandom_range(99) < 12) ? calclk_pkg::KIND_SET : calclk_pkg::KIND_TICK;
      item.hour_text   = 16'($urandom);
      item.minute_text = 16'($urandom);
      item.second_text = 16'($urandom);
      item.day_text    = 16'($urandom);
      item.month_text  = 16'($urandom);
      item.year_text   = 16'($urandom);
      return item;
   endfunction

   initial begin
      calclk_pkg::req_item_type item;
      int unsigned              ticks;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Ticks before the first set are lost.
      send_request({calclk_pkg::KIND_TICK, {6{16'h0000}}});
      send_request({calclk_pkg::KIND_TICK, {6{16'hFFFF}}});
      // The set loads the clock and shows it without a tick.
      send_request(pick_start());
      // Further sets leave the clock alone and do not advance it.
      send_request({calclk_pkg::KIND_SET, {6{16'h0000}}});
      send_request({calclk_pkg::KIND_SET, {6{16'hFFFF}}});
      repeat (20) send_request({calclk_pkg::KIND_TICK, {6{16'h3030}}});

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 74;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 74;
            end
            default: begin
               send_idle_pct = 25;
               rsp_stall_pct = 25;
            end
         endcase
         ticks = 0;
         while (ticks < PHASE_TICKS) begin
            item = random_request();
            if (item.kind == calclk_pkg::KIND_TICK) ticks++;
            send_request(item);
         end
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
